// ----- rtl/kdsl_pkg.sv -----
package kdsl_pkg;

	// Key debounce phases
	typedef enum logic [1:0] {
		PH_IDLE        = 2'd0,
		PH_DEB_PRESS   = 2'd1,
		PH_PRESSED     = 2'd2,
		PH_DEB_RELEASE = 2'd3
	} phase_t;

	// Result action codes
	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_SHORT   = 2'd1,
		ACT_LONG    = 2'd2,
		ACT_GUARDED = 2'd3
	} action_t;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOT_GUARD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOT_TIME  = 2'd3;

	// Field widths
	localparam int CNT_W  = 4;
	localparam int MS16_W = 16;
	localparam int TIME_W = 32;

	// Register reset values
	localparam logic [CNT_W-1:0]  DEBOUNCE_RST   = 4'd5;
	localparam logic [MS16_W-1:0] LONG_PRESS_RST = 16'd3000;
	localparam logic [MS16_W-1:0] BOOT_GUARD_RST = 16'd3000;
	localparam logic [TIME_W-1:0] BOOT_TIME_RST  = 32'd0;

	// One poll of the key
	typedef struct packed {
		logic              key_level;
		logic              read_ok;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	// One result per poll
	typedef struct packed {
		action_t action;
		logic    key_held;
		logic    long_reached;
	} out_item_t;

endpackage

// ----- rtl/kdsl_in_if.sv -----
interface kdsl_in_if;
	import kdsl_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/kdsl_out_if.sv -----
interface kdsl_out_if;
	import kdsl_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/key_debounce_short_long_press.sv -----
// Active-low key debouncer with short and long press detection.
// poll (sink): one transfer per key poll, carrying key_level (0 = pressed),
//   read_ok and the free-running millisecond time now_ms.
// result (source): exactly one transfer per poll, in poll order, carrying
//   action (none, short, long, short ignored in boot guard), key_held and
//   long_reached as they stand after that poll.
// cfg_we/cfg_index/cfg_data: register writes (debounce count, long press
//   time, boot guard time, boot timestamp); write only while idle.
// A taken poll waits in the input register, and once it advances its result
//   is loaded into the result register and offered on result.
// Throughput: one poll per cycle while result is not stalled; the state
//   update is one 32-bit subtract and compare plus a small phase update,
//   done in the cycle a poll leaves the input register.
// Reset: phase idle, counters and long flag clear, registers at defaults;
//   both valids drop.
// Stall: while result is held, one more poll waits in the input register;
//   after that poll.ready drops until result is taken.
module key_debounce_short_long_press (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kdsl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kdsl_pkg::CFG_DATA_W-1:0] cfg_data,
	kdsl_in_if.sink                         poll,
	kdsl_out_if.source                      result
);
	import kdsl_pkg::*;

	// configuration
	logic [CNT_W-1:0]  deb_q;
	logic [MS16_W-1:0] long_ms_q;
	logic [MS16_W-1:0] guard_ms_q;
	logic [TIME_W-1:0] boot_ms_q;

	// input register
	logic     valid_s1;
	in_item_t item_s1;

	// key state
	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [TIME_W-1:0] start_q, start_d;
	logic              long_q, long_d;

	// result register
	logic      out_valid_q;
	out_item_t out_item_q, out_item_d;

	logic              advance;
	logic [CNT_W-1:0]  cnt_inc;
	logic              cnt_done;
	logic [TIME_W-1:0] held_ms;
	logic [TIME_W-1:0] since_boot;
	logic              held_long;
	logic              in_guard;
	logic              release_done;

	// handshake
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q      <= DEBOUNCE_RST;
			long_ms_q  <= LONG_PRESS_RST;
			guard_ms_q <= BOOT_GUARD_RST;
			boot_ms_q  <= BOOT_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:   deb_q      <= cfg_data[CNT_W-1:0];
				CFG_LONG_PRESS: long_ms_q  <= cfg_data[MS16_W-1:0];
				CFG_BOOT_GUARD: guard_ms_q <= cfg_data[MS16_W-1:0];
				CFG_BOOT_TIME:  boot_ms_q  <= cfg_data[TIME_W-1:0];
				default:        ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			item_s1 <= poll.data;
		end
	end

	// shared arithmetic, time differences wrap mod 2^32
	assign cnt_inc    = count_q + CNT_W'(1);
	assign cnt_done   = (cnt_inc >= deb_q);
	assign held_ms    = item_s1.now_ms - start_q;
	assign since_boot = item_s1.now_ms - boot_ms_q;
	assign held_long  = (held_ms >= TIME_W'(long_ms_q));
	assign in_guard   = (boot_ms_q != '0) && (since_boot < TIME_W'(guard_ms_q));
	assign release_done = item_s1.read_ok && (phase_q == PH_DEB_RELEASE) &&
		item_s1.key_level && cnt_done;

	// next state
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		start_d = start_q;
		long_d  = long_q;
		if (item_s1.read_ok) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (!item_s1.key_level) begin
						phase_d = PH_DEB_PRESS;
						count_d = CNT_W'(1);
					end
				end
				PH_DEB_PRESS: begin
					if (!item_s1.key_level) begin
						count_d = cnt_inc;
						if (cnt_done) begin
							phase_d = PH_PRESSED;
							start_d = item_s1.now_ms;
							long_d  = 1'b0;
							count_d = '0;
						end
					end else begin
						phase_d = PH_IDLE;
						count_d = '0;
					end
				end
				PH_PRESSED: begin
					if (item_s1.key_level) begin
						phase_d = PH_DEB_RELEASE;
						count_d = CNT_W'(1);
					end else if (!long_q && held_long) begin
						long_d = 1'b1;
					end
				end
				PH_DEB_RELEASE: begin
					if (item_s1.key_level) begin
						count_d = cnt_inc;
						if (cnt_done) begin
							phase_d = PH_IDLE;
							count_d = '0;
							long_d  = 1'b0;
						end
					end else begin
						phase_d = PH_PRESSED;
						count_d = '0;
					end
				end
				default: ;
			endcase
		end
	end

	// result fields
	always_comb begin
		out_item_d.action = ACT_NONE;
		if (release_done) begin
			priority if (long_q || held_long) begin
				out_item_d.action = ACT_LONG;
			end else if (in_guard) begin
				out_item_d.action = ACT_GUARDED;
			end else begin
				out_item_d.action = ACT_SHORT;
			end
		end
		out_item_d.key_held     = (phase_d == PH_PRESSED) || (phase_d == PH_DEB_RELEASE);
		out_item_d.long_reached = long_d;
	end

	// state update, one poll per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			start_q <= '0;
			long_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			count_q <= count_d;
			start_q <= start_d;
			long_q  <= long_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= out_item_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_item_q;

endmodule

// ----- rtl/kdsl_chk.sv -----
module kdsl_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input kdsl_pkg::out_item_t res_data
);
	import kdsl_pkg::*;

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped or changed while stalled");

	// a reported press means the key went back to idle with the flag clear
	a_action_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.action != ACT_NONE) |->
		!res_data.key_held && !res_data.long_reached)
		else $error("press reported while key still held");

	// the long flag only stands during a held key
	a_long_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.long_reached |-> res_data.key_held)
		else $error("long flag set while key not held");

endmodule

bind key_debounce_short_long_press kdsl_chk u_kdsl_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);

// ----- tb/key_debounce_short_long_press_tb.sv -----
module key_debounce_short_long_press_tb;
	import kdsl_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_POLLS = 145;
	localparam int LONG_HOLD   = 80;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	kdsl_in_if  poll_ch();
	kdsl_out_if result_ch();

	key_debounce_short_long_press dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.poll      (poll_ch),
		.result    (result_ch)
	);

	// Shadow registers and key machine state
	logic [CNT_W-1:0]  debounce_reg   = DEBOUNCE_RST;
	logic [MS16_W-1:0] long_reg       = LONG_PRESS_RST;
	logic [MS16_W-1:0] guard_reg      = BOOT_GUARD_RST;
	logic [TIME_W-1:0] boot_stamp_reg = BOOT_TIME_RST;

	phase_t            kphase      = PH_IDLE;
	logic [CNT_W-1:0]  kcount      = '0;
	logic [TIME_W-1:0] press_stamp = '0;
	logic              long_seen   = 1'b0;

	out_item_t         pending[$];
	out_item_t         want;
	int                mismatches    = 0;
	int                polls_taken   = 0;
	int                cycle_count   = 0;
	int                hold_requests = 0;
	int                holds_served  = 0;
	bit                idle_enable   = 1'b0;
	logic [TIME_W-1:0] now_stamp     = '0;
	int                ms_step       = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Key machine: one poll in, the result it causes out
	function automatic out_item_t key_machine_step(input in_item_t p);
		out_item_t         r;
		logic [TIME_W-1:0] held;
		logic [TIME_W-1:0] since_boot;
		r.action = ACT_NONE;
		if (p.read_ok) begin
			case (kphase)
				PH_IDLE: begin
					if (!p.key_level) begin
						kphase = PH_DEB_PRESS;
						kcount = 4'd1;
					end
				end
				PH_DEB_PRESS: begin
					if (!p.key_level) begin
						kcount = kcount + 4'd1;
						if (kcount >= debounce_reg) begin
							kphase      = PH_PRESSED;
							press_stamp = p.now_ms;
							long_seen   = 1'b0;
							kcount      = '0;
						end
					end else begin
						kphase = PH_IDLE;
						kcount = '0;
					end
				end
				PH_PRESSED: begin
					held = p.now_ms - press_stamp;
					if (p.key_level) begin
						kphase = PH_DEB_RELEASE;
						kcount = 4'd1;
					end else if (!long_seen && held >= {16'd0, long_reg}) begin
						long_seen = 1'b1;
					end
				end
				default: begin
					if (p.key_level) begin
						kcount = kcount + 4'd1;
						if (kcount >= debounce_reg) begin
							held       = p.now_ms - press_stamp;
							since_boot = p.now_ms - boot_stamp_reg;
							if (long_seen || held >= {16'd0, long_reg})
								r.action = ACT_LONG;
							else if (boot_stamp_reg != '0 && since_boot < {16'd0, guard_reg})
								r.action = ACT_GUARDED;
							else
								r.action = ACT_SHORT;
							kphase    = PH_IDLE;
							kcount    = '0;
							long_seen = 1'b0;
						end
					end else begin
						kphase = PH_PRESSED;
						kcount = '0;
					end
				end
			endcase
		end
		r.key_held     = (kphase == PH_PRESSED || kphase == PH_DEB_RELEASE);
		r.long_reached = long_seen;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] want_v,
			input logic [31:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0h, got %0h", what, want_v, got_v);
	endtask

	// Result checker: each transfer against the oldest expectation
	always @(posedge clk) begin
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending.size() == 0) begin
				flag_mismatch("result with nothing expected", '0, 32'(result_ch.data));
			end else begin
				want = pending.pop_front();
				if (result_ch.data.action !== want.action)
					flag_mismatch("action", 32'(want.action),
						32'(result_ch.data.action));
				if (result_ch.data.key_held !== want.key_held)
					flag_mismatch("key_held", 32'(want.key_held),
						32'(result_ch.data.key_held));
				if (result_ch.data.long_reached !== want.long_reached)
					flag_mismatch("long_reached", 32'(want.long_reached),
						32'(result_ch.data.long_reached));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result receiver: random stalls plus the long hold-off on request
	initial begin
		int burst;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else if (idle_enable && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 10);
				result_ch.ready <= 1'b0;
				repeat (burst) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// One poll transfer; valid stays high unless a gap is inserted
	task automatic send_poll(input logic level, input logic ok, input logic [TIME_W-1:0] stamp);
		in_item_t item;
		int       gap;
		item.key_level = level;
		item.read_ok   = ok;
		item.now_ms    = stamp;
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			poll_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.data  <= item;
		@(posedge clk);
		while (poll_ch.ready !== 1'b1) @(posedge clk);
		pending.push_back(key_machine_step(item));
		if (ok)
			polls_taken++;
	endtask

	// Drop valid and wait for the block to drain
	task automatic settle();
		poll_ch.valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Write all registers; unused upper data bits carry junk
	task automatic configure(input logic [3:0] deb, input logic [15:0] lp,
			input logic [15:0] bg, input logic [31:0] bt);
		logic [31:0] junk;
		junk = $urandom();
		write_reg(CFG_DEBOUNCE, {junk[31:4], deb});
		write_reg(CFG_LONG_PRESS, {junk[15:0], lp});
		write_reg(CFG_BOOT_GUARD, {junk[31:16], bg});
		write_reg(CFG_BOOT_TIME, bt);
		cfg_we         <= 1'b0;
		debounce_reg   = deb;
		long_reg       = lp;
		guard_reg      = bg;
		boot_stamp_reg = bt;
	endtask

	// One key sample at the next time step, sometimes preceded by a failed read
	task automatic sample(input logic level);
		if ($urandom_range(0, 127) == 0)
			now_stamp += $urandom();
		else
			now_stamp += ms_step;
		if ($urandom_range(0, 19) == 0)
			send_poll(1'($urandom_range(0, 1)), 1'b0, now_stamp);
		send_poll(level, 1'b1, now_stamp);
	endtask

	// Press and release with bounce, glitches and a random hold
	task automatic key_sequence();
		int need;
		need    = (debounce_reg < 2) ? 2 : int'(debounce_reg);
		ms_step = $urandom_range(0, (2 * int'(long_reg)) / (2 * need + 4) + 1);
		repeat ($urandom_range(0, 3)) sample(1'($urandom_range(0, 1)));
		// short glitch that must not confirm
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, need - 1)) sample(1'b0);
			sample(1'b1);
		end
		repeat (need + $urandom_range(0, 6)) sample(1'b0);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, need - 1)) sample(1'b1);
			sample(1'b0);
		end
		repeat (need + $urandom_range(0, 2)) sample(1'b1);
	endtask

	task automatic noise_burst();
		ms_step = $urandom_range(0, 50);
		repeat ($urandom_range(1, 8)) sample(1'($urandom_range(0, 1)));
	endtask

	task automatic run_phase(input logic [3:0] deb, input logic [15:0] lp,
			input logic [15:0] bg, input logic [31:0] bt);
		int start;
		configure(deb, lp, bg, bt);
		start = polls_taken;
		while (polls_taken - start < PHASE_POLLS) begin
			if ($urandom_range(0, 4) == 0)
				noise_burst();
			else
				key_sequence();
		end
		settle();
	endtask

	// Default registers: idle sample and a failed read at the time extremes
	task automatic test_failed_read();
		send_poll(1'b1, 1'b1, 32'h0000_0000);
		send_poll(1'b0, 1'b0, 32'hFFFF_FFFF);
		settle();
	endtask

	// Zero debounce, press bounce, release bounce, short press inside boot guard
	task automatic test_bounce_and_guard();
		logic [31:0] t;
		configure(4'd0, 16'd100, 16'hFFFF, 32'd1);
		t = 32'd1000;
		send_poll(1'b0, 1'b1, t);
		send_poll(1'b1, 1'b1, t + 1);
		send_poll(1'b0, 1'b1, t + 2);
		send_poll(1'b0, 1'b1, t + 3);
		send_poll(1'b1, 1'b1, t + 4);
		send_poll(1'b0, 1'b1, t + 5);
		send_poll(1'b1, 1'b1, t + 6);
		send_poll(1'b1, 1'b1, t + 7);
	endtask

	// Long flag while held, then long decided at release time alone
	task automatic test_long_press();
		logic [31:0] t;
		t = 32'd2000;
		send_poll(1'b0, 1'b1, t);
		send_poll(1'b0, 1'b1, t + 10);
		send_poll(1'b0, 1'b1, t + 110);
		send_poll(1'b1, 1'b1, t + 120);
		send_poll(1'b1, 1'b1, t + 130);
		t = 32'd5000;
		send_poll(1'b0, 1'b1, t);
		send_poll(1'b0, 1'b1, t);
		send_poll(1'b1, 1'b1, t + 50);
		send_poll(1'b1, 1'b1, t + 100);
		settle();
	endtask

	// Held time across the 32-bit wrap, guard disabled
	task automatic test_time_wrap();
		logic [31:0] t;
		configure(4'd1, 16'hFFFF, 16'd0, 32'd0);
		t = 32'hFFFF_FFF0;
		send_poll(1'b0, 1'b1, t);
		send_poll(1'b0, 1'b1, t + 4);
		send_poll(1'b1, 1'b1, t + 32'h20);
		send_poll(1'b1, 1'b1, t + 32'h30);
		settle();
	endtask

	// Receiver holds off while polls keep coming until the input stalls
	task automatic test_backpressure();
		idle_enable = 1'b0;
		ms_step     = 10;
		hold_requests++;
		repeat (12) sample(1'b0);
		repeat (12) sample(1'b1);
		settle();
		idle_enable = 1'b1;
	endtask

	task automatic test_random_phases();
		now_stamp = $urandom();
		run_phase(4'd5, 16'd3000, 16'd3000, now_stamp + 32'd500);
		run_phase(4'd1, 16'd0, 16'd0, 32'd0);
		now_stamp = 32'hFFFF_F000;
		run_phase(4'd15, 16'hFFFF, 16'hFFFF, now_stamp);
		run_phase(4'd0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			32'hFFFF_FFFF);
		run_phase(4'd2, 16'd200, 16'hFFFF, now_stamp - 32'd100);
		now_stamp = $urandom();
		run_phase(4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), now_stamp + $urandom_range(0, 65535));
		run_phase(4'($urandom_range(0, 15)), 16'($urandom_range(0, 4000)),
			16'($urandom_range(0, 65535)), $urandom());
		// closing stretch runs without idling
		idle_enable = 1'b0;
		run_phase(4'd3, 16'd1000, 16'd5000, now_stamp);
	endtask

	// Sequence of tests
	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_DEBOUNCE;
		cfg_data      <= '0;
		poll_ch.valid <= 1'b0;
		poll_ch.data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_enable = 1'b1;

		test_failed_read();
		test_bounce_and_guard();
		test_long_press();
		test_time_wrap();
		test_backpressure();
		test_random_phases();

		settle();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
